// ===== hw/rtl/ssp_pkg.sv =====
package ssp_pkg;

    localparam int POS_W      = 15;
    localparam int PULSE_W    = 16;
    localparam int SLEW_W     = 20;
    localparam int US_W       = 20;
    localparam int CH_W       = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int PROD_W = SLEW_W + US_W;
    localparam int REM_W  = 20;
    localparam int Q_W    = 21;
    localparam int CNT_W  = 5;
    localparam int US19_W = 19;

    localparam logic signed [PULSE_W-1:0] TGT_HI = 16'sd10000;
    localparam logic signed [PULSE_W-1:0] TGT_LO = -16'sd10000;

    localparam logic [REM_W-1:0] US_PER_S   = 20'd1000000;
    localparam logic [REM_W-1:0] POS_SCALE  = 20'd10000;
    localparam logic [POS_W-1:0] STEP_LIMIT = 15'd20000;

    localparam logic [CNT_W-1:0] STEP_MUL_LAST = 5'd19;
    localparam logic [CNT_W-1:0] STEP_DIV_LAST = 5'd20;
    localparam logic [CNT_W-1:0] MAP_MUL_LAST  = 5'd13;
    localparam logic [CNT_W-1:0] MAP_DIV_LAST  = 5'd15;

    localparam logic [PULSE_W-1:0] RST_MIN_PULSE     = 16'd16000;
    localparam logic [PULSE_W-1:0] RST_MAX_PULSE     = 16'd32000;
    localparam logic [PULSE_W-1:0] RST_NEUTRAL_PULSE = 16'd24000;
    localparam logic [PULSE_W-1:0] RST_DEADBAND      = 16'd0;
    localparam logic [SLEW_W-1:0]  RST_SLEW_RATE     = 20'd10000;
    localparam logic [CH_W-1:0]    RST_CHANNEL       = 4'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_PULSE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_RATE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CHANNEL = 3'd5;

    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_MOVE,
        S_MAP,
        S_DEAD,
        S_CLAMP
    } t_state;

endpackage

// ===== hw/rtl/ssp_if.sv =====
interface ssp_in_if import ssp_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic signed [PULSE_W-1:0] target_pct;
    logic [US_W-1:0]           elapsed_us;

    modport source (output valid, output kind, output target_pct, output elapsed_us,
                    input ready);
    modport sink   (input valid, input kind, input target_pct, input elapsed_us,
                    output ready);
endinterface

interface ssp_out_if import ssp_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    channel;
    logic [PULSE_W-1:0] pulse_width;

    modport source (output valid, output channel, output pulse_width, input ready);
    modport sink   (input valid, input channel, input pulse_width, output ready);
endinterface

interface ssp_cfg_if import ssp_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/servo_slew_pulse_mapper.sv =====
// channel   dir  payload                               word accepted when
// i_in      in   kind, target_pct, elapsed_us          valid && ready
// o_out     out  channel, pulse_width                  valid && ready
// i_cfg     in   index, data                           valid && ready (ready always high)
//
// a tick's result is computed by one shared bit-serial multiply and restoring divide
// unit: 20 + 21 steps for the slew step, 14 + 16 for the mapping, the mapping being
// skipped when the new position is zero
// i_in is ready only while idle; a result waits in the output register, and a
// stalled o_out holds the next tick in its clamp state until the register frees
// synchronous active-low reset restores register defaults and zero positions
module servo_slew_pulse_mapper import ssp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssp_in_if.sink     i_in,
    ssp_out_if.source  o_out,
    ssp_cfg_if.sink    i_cfg
);

    logic [PULSE_W-1:0] r_min;
    logic [PULSE_W-1:0] r_max;
    logic [PULSE_W-1:0] r_neu;
    logic [PULSE_W-1:0] r_db;
    logic [SLEW_W-1:0]  r_slew;
    logic [CH_W-1:0]    r_chan;

    logic signed [POS_W-1:0] r_tgt, n_tgt;
    logic signed [POS_W-1:0] r_cur, n_cur;

    t_state r_state, n_state;
    logic   r_map, n_map;
    logic   r_sneg, n_sneg;

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic [SLEW_W-1:0] r_mcand, n_mcand;
    logic [US_W-1:0]   r_mplier, n_mplier;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [Q_W-1:0]    r_q, n_q;

    logic signed [US19_W-1:0] r_us, n_us;

    logic               r_out_valid, n_out_valid;
    logic [CH_W-1:0]    r_out_chan, n_out_chan;
    logic [PULSE_W-1:0] r_out_pulse, n_out_pulse;

    logic in_acc;
    logic out_free;

    logic [PROD_W-1:0] mul_sum;
    logic [Q_W-1:0]    div_t;
    logic [Q_W-1:0]    div_d;
    logic              div_ge;
    logic [Q_W-1:0]    div_r;

    logic [POS_W-1:0]          step;
    logic signed [PULSE_W-1:0] err;
    logic [PULSE_W-1:0]        mag;
    logic signed [PULSE_W-1:0] moved;

    logic                      p_neg;
    logic [POS_W-1:0]          p_mag;
    logic signed [PULSE_W:0]   span;
    logic [PULSE_W-1:0]        s_mag;

    logic signed [US19_W-1:0] q19;
    logic signed [US19_W-1:0] delta;
    logic signed [US19_W-1:0] neu19;
    logic signed [US19_W-1:0] half19;
    logic signed [US19_W-1:0] us_pos;
    logic signed [US19_W-1:0] us_neg;
    logic signed [US19_W-1:0] min19;
    logic signed [US19_W-1:0] max19;
    logic [PULSE_W-1:0]       pulse;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready        = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_out_valid;
    assign o_out.channel     = r_out_chan;
    assign o_out.pulse_width = r_out_pulse;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= RST_MIN_PULSE;
            r_max  <= RST_MAX_PULSE;
            r_neu  <= RST_NEUTRAL_PULSE;
            r_db   <= RST_DEADBAND;
            r_slew <= RST_SLEW_RATE;
            r_chan <= RST_CHANNEL;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_MIN_PULSE:      r_min  <= i_cfg.data[PULSE_W-1:0];
                CFG_MAX_PULSE:      r_max  <= i_cfg.data[PULSE_W-1:0];
                CFG_NEUTRAL_PULSE:  r_neu  <= i_cfg.data[PULSE_W-1:0];
                CFG_DEADBAND_WIDTH: r_db   <= i_cfg.data[PULSE_W-1:0];
                CFG_SLEW_RATE:      r_slew <= i_cfg.data[SLEW_W-1:0];
                CFG_OUTPUT_CHANNEL: r_chan <= i_cfg.data[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // shared serial arithmetic
    always_comb begin
        mul_sum = {r_acc[PROD_W-2:0], 1'b0}
                + (r_mplier[US_W-1] ? {{(PROD_W-SLEW_W){1'b0}}, r_mcand} : '0);
        div_t   = {r_rem, r_acc[Q_W-1]};
        div_d   = r_map ? {1'b0, POS_SCALE} : {1'b0, US_PER_S};
        div_ge  = (div_t >= div_d);
        div_r   = div_t - div_d;
    end

    // slew step and position update
    always_comb begin
        step  = (r_q > Q_W'(STEP_LIMIT)) ? STEP_LIMIT : r_q[POS_W-1:0];
        err   = PULSE_W'(r_tgt) - PULSE_W'(r_cur);
        mag   = err[PULSE_W-1] ? PULSE_W'(-err) : PULSE_W'(err);
        moved = err[PULSE_W-1] ? (PULSE_W'(r_cur) - signed'({1'b0, step}))
                               : (PULSE_W'(r_cur) + signed'({1'b0, step}));
    end

    // mapping operands
    always_comb begin
        p_neg = r_cur[POS_W-1];
        p_mag = p_neg ? POS_W'(-r_cur) : POS_W'(r_cur);
        span  = p_neg ? (signed'({1'b0, r_neu}) - signed'({1'b0, r_min}))
                      : (signed'({1'b0, r_max}) - signed'({1'b0, r_neu}));
        s_mag = span[PULSE_W] ? PULSE_W'(-span) : PULSE_W'(span);
    end

    // deadband and end-stop clamp
    always_comb begin
        q19    = signed'({3'b000, r_q[PULSE_W-1:0]});
        delta  = r_sneg ? -q19 : q19;
        neu19  = signed'({3'b000, r_neu});
        half19 = signed'({4'b0000, r_db[PULSE_W-1:1]});
        min19  = signed'({3'b000, r_min});
        max19  = signed'({3'b000, r_max});
        us_pos = neu19 + delta;
        us_neg = neu19 - delta;
        if (r_us < min19) begin
            pulse = r_min;
        end else if (r_us > max19) begin
            pulse = r_max;
        end else begin
            pulse = r_us[PULSE_W-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.kind == KIND_TICK) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_cnt == '0) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = r_map ? S_DEAD : S_MOVE;
                end
            end
            S_MOVE:  n_state = S_MAP;
            S_MAP:   n_state = (r_cur == '0) ? S_DEAD : S_MUL;
            S_DEAD:  n_state = S_CLAMP;
            S_CLAMP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_tgt       = r_tgt;
        n_cur       = r_cur;
        n_map       = r_map;
        n_sneg      = r_sneg;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_rem       = r_rem;
        n_q         = r_q;
        n_us        = r_us;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_chan  = r_out_chan;
        n_out_pulse = r_out_pulse;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.kind == KIND_TICK) begin
                        n_map    = 1'b0;
                        n_acc    = '0;
                        n_mcand  = r_slew;
                        n_mplier = i_in.elapsed_us;
                        n_cnt    = STEP_MUL_LAST;
                    end else if (i_in.target_pct > TGT_HI) begin
                        n_tgt = POS_W'(TGT_HI);
                    end else if (i_in.target_pct < TGT_LO) begin
                        n_tgt = POS_W'(TGT_LO);
                    end else begin
                        n_tgt = i_in.target_pct[POS_W-1:0];
                    end
                end
            end
            S_MUL: begin
                n_mplier = {r_mplier[US_W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    if (r_map) begin
                        n_rem = REM_W'(mul_sum[29:16]);
                        n_acc = mul_sum << 5;
                        n_cnt = MAP_DIV_LAST;
                    end else begin
                        n_rem = REM_W'(mul_sum[PROD_W-1:Q_W]);
                        n_acc = mul_sum;
                        n_cnt = STEP_DIV_LAST;
                    end
                end else begin
                    n_acc = mul_sum;
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DIV: begin
                n_rem = div_ge ? div_r[REM_W-1:0] : div_t[REM_W-1:0];
                n_q   = {r_q[Q_W-2:0], div_ge};
                n_acc = {r_acc[PROD_W-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
            end
            S_MOVE: begin
                if (mag > {1'b0, step}) begin
                    n_cur = moved[POS_W-1:0];
                end else begin
                    n_cur = r_tgt;
                end
            end
            S_MAP: begin
                n_map    = 1'b1;
                n_sneg   = span[PULSE_W];
                n_acc    = '0;
                n_mcand  = SLEW_W'(s_mag);
                n_mplier = {p_mag[13:0], 6'b000000};
                n_cnt    = MAP_MUL_LAST;
                n_q      = '0;
            end
            S_DEAD: begin
                if (r_cur == '0) begin
                    n_us = neu19;
                end else if (!r_cur[POS_W-1]) begin
                    n_us = (us_pos < neu19 + half19) ? (neu19 + half19) : us_pos;
                end else begin
                    n_us = (us_neg > neu19 - half19) ? (neu19 - half19) : us_neg;
                end
            end
            S_CLAMP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_chan  = r_chan;
                    n_out_pulse = pulse;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tgt       <= '0;
            r_cur       <= '0;
            r_map       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tgt       <= n_tgt;
            r_cur       <= n_cur;
            r_map       <= n_map;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sneg      <= n_sneg;
        r_cnt       <= n_cnt;
        r_acc       <= n_acc;
        r_mcand     <= n_mcand;
        r_mplier    <= n_mplier;
        r_rem       <= n_rem;
        r_q         <= n_q;
        r_us        <= n_us;
        r_out_chan  <= n_out_chan;
        r_out_pulse <= n_out_pulse;
    end

endmodule
